[src/thrc_pkg.sv]
package thrc_pkg;

   localparam int TIME_BINS   = 131072;
   localparam int COUNT_BITS  = 32;
   localparam int ANSWER_BITS = 33;
   localparam int STATUS_BITS = 2;
   localparam int ACTION_BITS = 3;
   localparam int TIME_BITS   = 24;
   localparam int RAW_BITS    = 20;
   localparam int IDX_BITS    = $clog2(TIME_BINS);
   localparam int WALK_BITS   = $clog2(TIME_BINS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int W_HOUR_TENS = 36000;
   localparam int W_HOUR_ONES = 3600;
   localparam int W_MIN_TENS  = 600;
   localparam int W_MIN_ONES  = 60;
   localparam int W_SEC_TENS  = 10;

   localparam logic [ACTION_BITS-1:0] ACT_RECORD = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_BUILD  = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_TOTAL  = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_PERIOD = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_AT     = 3'd4;

   localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_RANGE     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [IDX_BITS-1:0]    idx_a;
      logic                   a_bad;
      logic [IDX_BITS-1:0]    idx_b;
      logic                   b_bad;
   } thrc_cmd_type;

   function automatic logic [RAW_BITS-1:0] thrc_time_index(input logic [TIME_BITS-1:0] t);
      return RAW_BITS'(t[23:20]) * RAW_BITS'(W_HOUR_TENS)
           + RAW_BITS'(t[19:16]) * RAW_BITS'(W_HOUR_ONES)
           + RAW_BITS'(t[15:12]) * RAW_BITS'(W_MIN_TENS)
           + RAW_BITS'(t[11:8])  * RAW_BITS'(W_MIN_ONES)
           + RAW_BITS'(t[7:4])   * RAW_BITS'(W_SEC_TENS)
           + RAW_BITS'(t[3:0]);
   endfunction

   function automatic logic [COUNT_BITS-1:0] thrc_sat_add(input logic [COUNT_BITS-1:0] a,
                                                          input logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
   endfunction

endpackage

[src/thrc_channels.sv]
interface thrc_req_if import thrc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic [TIME_BITS-1:0]   time_a;
   logic [TIME_BITS-1:0]   time_b;

   modport source (output valid, action, time_a, time_b, input ready);
   modport sink   (input valid, action, time_a, time_b, output ready);
endinterface

interface thrc_rsp_if import thrc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [ANSWER_BITS-1:0] answer;
   logic [STATUS_BITS-1:0]        status;

   modport source (output valid, answer, status, input ready);
   modport sink   (input valid, answer, status, output ready);
endinterface

[src/time_histogram_range_count_core.sv]
// Channel   Beat contents                     Direction
// req_chan  action, time_a, time_b            in
// rsp_chan  answer (signed), status           out
//
// Record, time and period beats pass from S_IDLE into S_RMW or S_QUERY in the back
// end, for the read and then write or read of the bin and prefix memories; a total
// beat and a beat turned away by the range or build check are answered from S_IDLE.
// A build beat walks the bin memory once in S_BUILD.
// After reset a clearing pass zeroes all TIME_BINS (131072) bins of the bin memory,
// during which req_chan.ready stays low.
// A two-entry command queue lets the front take beats while the back end works,
// and the back end waits only while the response register is still full.
module time_histogram_range_count_core import thrc_pkg::*; (
   input logic        clock,
   input logic        reset,
   thrc_req_if.sink   req_chan,
   thrc_rsp_if.source rsp_chan
);

   logic         clearing;
   logic         queue_full;
   logic         push;
   thrc_cmd_type push_cmd;
   logic         pop;
   logic         head_valid;
   thrc_cmd_type head;

   thrc_front u_front (
      .req        (req_chan),
      .clearing   (clearing),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   thrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   thrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp        (rsp_chan)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("Command pushed into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("Command popped from an empty queue.");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_chan.ready && !push && !pop)
      else $error("Beat taken during the clearing pass.");

   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      pop |=> !($past(rsp_chan.valid) && !$past(rsp_chan.ready)) || $stable(rsp_chan.answer))
      else $error("Response register overwritten before it was taken.");

endmodule

[src/thrc_front.sv]
module thrc_front import thrc_pkg::*; (
   thrc_req_if.sink     req,
   input  logic         clearing,
   input  logic         queue_full,
   output logic         push,
   output thrc_cmd_type cmd
);

   logic [RAW_BITS-1:0] raw_a;
   logic [RAW_BITS-1:0] raw_b;
   logic                known;

   assign raw_a = thrc_time_index(req.time_a);
   assign raw_b = thrc_time_index(req.time_b);

   // Unused action codes are taken and dropped here.
   assign known = (req.action == ACT_RECORD) || (req.action == ACT_BUILD) ||
                  (req.action == ACT_TOTAL) || (req.action == ACT_PERIOD) ||
                  (req.action == ACT_AT);

   assign req.ready  = !queue_full && !clearing;
   assign push       = req.valid && req.ready && known;
   assign cmd.action = req.action;
   assign cmd.idx_a  = raw_a[IDX_BITS-1:0];
   assign cmd.a_bad  = raw_a >= RAW_BITS'(TIME_BINS);
   assign cmd.idx_b  = raw_b[IDX_BITS-1:0];
   assign cmd.b_bad  = raw_b >= RAW_BITS'(TIME_BINS);

endmodule

[src/thrc_queue.sv]
module thrc_queue import thrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  thrc_cmd_type push_cmd,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output thrc_cmd_type head
);

   thrc_cmd_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/thrc_back.sv]
module thrc_back import thrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  thrc_cmd_type head,
   output logic         pop,
   output logic         clearing,
   thrc_rsp_if.source   rsp
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RMW   = 3'd2;
   localparam logic [2:0] S_BUILD = 3'd3;
   localparam logic [2:0] S_QUERY = 3'd4;

   logic [COUNT_BITS-1:0] bin_mem [TIME_BINS];
   logic [COUNT_BITS-1:0] pre_mem [TIME_BINS];

   logic [2:0]                    state_ff, state_in;
   logic [WALK_BITS-1:0]          walk_ff, walk_in;
   logic                          pend_ff, pend_in;
   logic [IDX_BITS-1:0]           pend_addr_ff, pend_addr_in;
   logic [COUNT_BITS-1:0]         run_ff, run_in;
   logic [COUNT_BITS-1:0]         total_ff, total_in;
   logic                          sums_ok_ff, sums_ok_in;
   logic [IDX_BITS-1:0]           cmd_idx_ff, cmd_idx_in;
   logic                          is_period_ff, is_period_in;
   logic                          a_zero_ff, a_zero_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [ANSWER_BITS-1:0] rsp_answer_ff, rsp_answer_in;
   logic [STATUS_BITS-1:0]        rsp_status_ff, rsp_status_in;

   logic [COUNT_BITS-1:0] bin_rd_ff;
   logic [COUNT_BITS-1:0] pre_hi_ff;
   logic [COUNT_BITS-1:0] pre_lo_ff;

   logic                  bin_we;
   logic [IDX_BITS-1:0]   bin_waddr;
   logic [COUNT_BITS-1:0] bin_wdata;
   logic [IDX_BITS-1:0]   bin_raddr;
   logic                  pre_we;
   logic [COUNT_BITS-1:0] run_next;
   logic [COUNT_BITS-1:0] lo_value;

   assign clearing   = state_ff == S_CLEAR;
   assign run_next   = thrc_sat_add(run_ff, bin_rd_ff);
   assign lo_value   = a_zero_ff ? '0 : pre_lo_ff;
   assign bin_raddr  = (state_ff == S_BUILD) ? walk_ff[IDX_BITS-1:0] : head.idx_a;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.answer = rsp_answer_ff;
   assign rsp.status = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      run_in        = run_ff;
      total_in      = total_ff;
      sums_ok_in    = sums_ok_ff;
      cmd_idx_in    = cmd_idx_ff;
      is_period_in  = is_period_ff;
      a_zero_in     = a_zero_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_answer_in = rsp_answer_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      bin_we        = 1'b0;
      bin_waddr     = walk_ff[IDX_BITS-1:0];
      bin_wdata     = '0;
      pre_we        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            bin_we  = 1'b1;
            walk_in = walk_ff + 1'b1;
            if (walk_ff == WALK_BITS'(TIME_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // The output register is free whenever a command is taken, so every
            // result below lands in it without a wait.
            if (head_valid && (!rsp_valid_ff || rsp.ready)) begin
               pop = 1'b1;
               unique case (head.action)
                  ACT_RECORD: begin
                     total_in   = thrc_sat_add(total_ff, COUNT_BITS'(1));
                     sums_ok_in = 1'b0;
                     if (head.a_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_answer_in = '0;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        cmd_idx_in = head.idx_a;
                        state_in   = S_RMW;
                     end
                  end
                  ACT_BUILD: begin
                     walk_in  = '0;
                     pend_in  = 1'b0;
                     run_in   = '0;
                     state_in = S_BUILD;
                  end
                  ACT_TOTAL: begin
                     rsp_valid_in  = 1'b1;
                     rsp_answer_in = ANSWER_BITS'(total_ff);
                     rsp_status_in = STAT_OK;
                  end
                  ACT_PERIOD: begin
                     if (!sums_ok_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_answer_in = '0;
                        rsp_status_in = STAT_NOT_BUILT;
                     end else if (head.a_bad || head.b_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_answer_in = '0;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        is_period_in = 1'b1;
                        a_zero_in    = head.idx_a == '0;
                        state_in     = S_QUERY;
                     end
                  end
                  ACT_AT: begin
                     if (head.a_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_answer_in = '0;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        is_period_in = 1'b0;
                        state_in     = S_QUERY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RMW: begin
            bin_we    = 1'b1;
            bin_waddr = cmd_idx_ff;
            bin_wdata = thrc_sat_add(bin_rd_ff, COUNT_BITS'(1));
            state_in  = S_IDLE;
         end
         S_BUILD: begin
            // One bin is read per cycle; its running sum is written in the cycle after its read.
            if (walk_ff < WALK_BITS'(TIME_BINS)) begin
               walk_in      = walk_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = walk_ff[IDX_BITS-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               pre_we = 1'b1;
               run_in = run_next;
            end else if (walk_ff == WALK_BITS'(TIME_BINS)) begin
               sums_ok_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_QUERY: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            if (is_period_ff) begin
               rsp_answer_in = ANSWER_BITS'(pre_hi_ff) - ANSWER_BITS'(lo_value);
            end else begin
               rsp_answer_in = ANSWER_BITS'(bin_rd_ff);
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         walk_ff      <= '0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         sums_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         sums_ok_ff   <= sums_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff  <= pend_addr_in;
      run_ff        <= run_in;
      cmd_idx_ff    <= cmd_idx_in;
      is_period_ff  <= is_period_in;
      a_zero_ff     <= a_zero_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      bin_rd_ff <= bin_mem[bin_raddr];
   end

   always_ff @(posedge clock) begin
      if (pre_we) begin
         pre_mem[pend_addr_ff] <= run_next;
      end
      pre_hi_ff <= pre_mem[head.idx_b];
      pre_lo_ff <= pre_mem[head.idx_a - 1'b1];
   end

endmodule
